@@ hdl/lcg_random_with_range_top_assert.svh @@
// Assertion macros for the LCG random-with-range block.
`ifndef LCG_RANDOM_WITH_RANGE_TOP_ASSERT_SVH
`define LCG_RANDOM_WITH_RANGE_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define LCGR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcgr same-cycle check failed");

// Next-cycle implication, checked on clk, idle during reset.
`define LCGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcgr next-cycle check failed");

`endif

@@ hdl/lcgr_pkg.sv @@
// Package: types and constants of the LCG random-with-range block.
package lcgr_pkg;

    localparam int unsigned ValW  = 31;
    localparam int unsigned SeedW = 32;
    localparam int unsigned CntW  = 5;

    localparam logic [ValW-1:0] LcgMul  = 31'd1103515245;
    localparam logic [ValW-1:0] LcgInc  = 31'd12345;
    localparam logic [ValW-1:0] ValMax  = 31'h7fffffff;
    localparam logic [CntW-1:0] DivSteps = 5'd31;

    localparam logic CmdRaw    = 1'b0;
    localparam logic CmdRanged = 1'b1;

    typedef struct packed {
        logic            command;
        logic [ValW-1:0] range_top;
    } req_t;

    typedef struct packed {
        logic [ValW-1:0] value;
        logic            error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_TOP,
        ST_ADVANCE,
        ST_START_Q,
        ST_DIV_Q,
        ST_FINISH
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;      // latch accepted request
        logic advance;      // step the generator
        logic div_start;    // start the divider
        logic div_top;      // divider source: max/top (1) or state/divisor (0)
        logic save_divisor; // keep max/top quotient
        logic sel_raw;      // result <- next generator state
        logic sel_zero;     // result <- zero range error
        logic sel_quo;      // result <- accepted quotient
        logic load_out;     // result -> output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic ranged;
        logic top_zero;
        logic div_busy;
        logic quo_ok;
    } status_t;

endpackage

@@ hdl/lcgr_divider.sv @@
// Restoring divider: one quotient bit per cycle while busy.
module lcgr_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lcgr_pkg::ValW-1:0] dividend,
    input  logic [lcgr_pkg::ValW-1:0] divisor,
    output logic                      busy,
    output logic [lcgr_pkg::ValW-1:0] quotient
);
    import lcgr_pkg::*;

    logic [CntW-1:0] count_reg, count_next;
    logic [ValW-1:0] rem_reg, rem_next;
    logic [ValW-1:0] quo_reg, quo_next;
    logic [ValW-1:0] dvs_reg, dvs_next;
    logic [ValW:0]   trial;

    assign trial = {rem_reg, quo_reg[ValW-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            count_next = DivSteps;
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy)
        begin
            count_next = count_reg - 1'b1;
            if (!trial[ValW])
            begin
                rem_next = trial[ValW-1:0];
                quo_next = {quo_reg[ValW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[ValW-2:0], quo_reg[ValW-1]};
                quo_next = {quo_reg[ValW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

@@ hdl/lcgr_datapath.sv @@
// Datapath: generator state, request and result registers, shared divider.
module lcgr_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lcgr_pkg::req_t             req,
    input  logic                       seed_wr,
    input  logic [lcgr_pkg::SeedW-1:0] seed,
    input  lcgr_pkg::cmd_t             cmd,
    output lcgr_pkg::status_t          status,
    output lcgr_pkg::rsp_t             rsp
);
    import lcgr_pkg::*;

    req_t            req_reg;
    logic [ValW-1:0] lcg_state_reg, lcg_state_next;
    logic [ValW-1:0] lcg_adv;
    logic [ValW-1:0] product;
    logic [ValW-1:0] divisor_reg;
    rsp_t            res_reg, res_next;
    rsp_t            rsp_reg;
    logic [ValW-1:0] div_dividend;
    logic [ValW-1:0] div_divisor;
    logic            div_busy;
    logic [ValW-1:0] div_quotient;

    // mod 2^31 falls out of the 31-bit result width
    assign product = lcg_state_reg * LcgMul;
    assign lcg_adv = product + LcgInc;

    always_comb
    begin
        lcg_state_next = lcg_state_reg;
        if (seed_wr)
        begin
            lcg_state_next = seed[ValW-1:0];
        end
        else if (cmd.advance)
        begin
            lcg_state_next = lcg_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_state_reg <= 31'd1;
        end
        else
        begin
            lcg_state_reg <= lcg_state_next;
        end
    end

    assign div_dividend = cmd.div_top ? ValMax        : lcg_state_reg;
    assign div_divisor  = cmd.div_top ? req_reg.range_top : divisor_reg;

    lcgr_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb
    begin
        res_next = res_reg;
        if (cmd.sel_raw)
        begin
            res_next = '{value: lcg_adv, error: 1'b0};
        end
        else if (cmd.sel_zero)
        begin
            res_next = '{value: '0, error: 1'b1};
        end
        else if (cmd.sel_quo)
        begin
            res_next = '{value: div_quotient, error: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.save_divisor)
        begin
            divisor_reg <= div_quotient;
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign status.ranged   = (req_reg.command == CmdRanged);
    assign status.top_zero = (req_reg.range_top == '0);
    assign status.div_busy = div_busy;
    assign status.quo_ok   = (div_quotient < req_reg.range_top);
    assign rsp             = rsp_reg;

endmodule

@@ hdl/lcgr_ctrl.sv @@
// Controller: request sequencing, rejection loop and output valid.
module lcgr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  lcgr_pkg::status_t status,
    output lcgr_pkg::cmd_t    cmd
);
    import lcgr_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.ranged || status.top_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV_TOP;
                end
            end
            ST_DIV_TOP:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                state_next = ST_START_Q;
            end
            ST_START_Q:
            begin
                state_next = ST_DIV_Q;
            end
            ST_DIV_Q:
            begin
                if (!status.div_busy)
                begin
                    state_next = status.quo_ok ? ST_FINISH : ST_ADVANCE;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_DECODE:
            begin
                if (!status.ranged)
                begin
                    cmd.advance = 1'b1;
                    cmd.sel_raw = 1'b1;
                end
                else if (status.top_zero)
                begin
                    cmd.sel_zero = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_top   = 1'b1;
                end
            end
            ST_DIV_TOP:
            begin
                cmd.save_divisor = !status.div_busy;
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
            end
            ST_START_Q:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_Q:
            begin
                cmd.sel_quo = !status.div_busy && status.quo_ok;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign rsp_valid_next = cmd.load_out | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ hdl/lcg_random_with_range_top.sv @@
// Top level of the LCG random-with-range block.
// A 31-bit linear congruential generator, state <- (state * 1103515245 + 12345)
// mod 2^31, reset to 1 and reloaded from the low 31 bits of cfg_data on every
// seed write (cfg_ready is always high; write only while no item is in flight).
// Each req item asks for a raw draw (command 0: the next state) or a draw in
// [0, range_top) (command 1): divisor = 0x7fffffff / range_top, then the
// generator is stepped and state / divisor taken until the quotient is below
// range_top. range_top of 0 gives error = 1, value = 0, and leaves the state
// alone. One item is worked on at a time. A raw or zero-range item goes from
// accept through decode to the result load; a ranged item also runs the shared
// one-bit-per-cycle divider once for the divisor and once per draw, until one
// draw is accepted (1 or 2 draws on average). A new item is taken while the
// previous result still waits in the rsp register.
module lcg_random_with_range_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  lcgr_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output lcgr_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lcgr_pkg::SeedW-1:0] cfg_data
);
    import lcgr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    seed_wr;

    // seed writes are taken at any time
    assign cfg_ready = 1'b1;
    assign seed_wr   = cfg_valid & cfg_ready;

    lcgr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lcgr_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .seed_wr (seed_wr),
        .seed    (cfg_data),
        .cmd     (cmd),
        .status  (status),
        .rsp     (rsp)
    );

`include "lcg_random_with_range_top_assert.svh"

    // in the cycle after an accepted item the block stalls new items
    `LCGR_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    // an error result always carries a zero value
    `LCGR_ASSERT_SAME(a_error_zero_value, rsp_valid && rsp.error, rsp.value == '0)

endmodule

@@ tb/testbench.sv @@
// Testbench for lcg_random_with_range_top: raw and ranged draws checked against a local LCG model.
`timescale 1ns / 1ps

module testbench;

    import lcgr_pkg::*;

    // LCG constants, kept at 64 bits so the product never loses a bit
    localparam bit [63:0] LCG_MULT   = 64'd1103515245;
    localparam bit [63:0] LCG_INC    = 64'd12345;
    localparam bit [30:0] FULL_SCALE = 31'h7fffffff;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    req_t           req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    rsp_t           rsp;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [SeedW-1:0] cfg_data = '0;

    // Local copy of the generator state; reset loads seed 1
    bit [30:0] gen_state = 31'd1;

    // Draws accepted by the block whose results have not come back yet
    rsp_t pending_draws[$];
    int   mismatches = 0;

    // Random idling on both channels; cleared for steady stretches
    bit   idling = 1'b1;
    int   stall_left = 0;

    lcg_random_with_range_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------

    // One LCG step: state <- (state * mult + inc) mod 2^31
    function automatic bit [30:0] step_generator();
        bit [63:0] prod;
        prod = {33'd0, gen_state} * LCG_MULT + LCG_INC;
        gen_state = prod[30:0];
        return gen_state;
    endfunction

    // Result of one draw; advances the model state as the block does.
    // Zero range flags an error and leaves the state untouched.
    function automatic rsp_t predict_draw(input req_t item);
        rsp_t      result;
        bit [30:0] divisor;
        bit [30:0] quot;
        result = '0;
        if (item.command == CmdRaw)
            result.value = step_generator();
        else if (item.range_top == '0)
            result.error = 1'b1;
        else
        begin
            divisor = FULL_SCALE / item.range_top;
            // reject quotients at or above the bound and draw again
            do
                quot = step_generator() / divisor;
            while (quot >= item.range_top);
            result.value = quot;
        end
        return result;
    endfunction

    function automatic req_t make_req(input logic cmd, input logic [ValW-1:0] top);
        req_t item;
        item.command   = cmd;
        item.range_top = top;
        return item;
    endfunction

    // Random item: bounds weighted toward the interesting corners
    function automatic req_t rand_request();
        logic [ValW-1:0] top;
        int unsigned     pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            top = '0;                                          // zero range
        else if (pick <= 4)
            top = ValW'($urandom_range(1, 16));                // tiny bounds, big divisor
        else if (pick <= 7)
            top = 31'h3ffffff0 + ValW'($urandom_range(0, 32)); // divisor flips 2 -> 1 here
        else if (pick <= 9)
            top = 31'h7fffff00 + ValW'($urandom_range(0, 255)); // near full scale
        else
            top = ValW'($urandom());
        return make_req($urandom_range(0, 1) ? CmdRanged : CmdRaw, top);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers (inputs move on the falling edge)
    // ------------------------------------------------------------------

    // Offer one item; valid stays high so back-to-back items need no bubble
    task automatic send_request(input req_t item);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        pending_draws.push_back(predict_draw(item));
    endtask

    // Drop valid after the last item of a stream
    task automatic end_stream();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Block is idle once every result is back; a short pause covers the output stage
    task automatic wait_drained();
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Seed write: only low 31 bits reach the state
    task automatic write_seed(input logic [SeedW-1:0] seed);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (!cfg_ready);
        gen_state = seed[30:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker (outputs sampled on the rising edge)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: result with nothing expected: value=%h error=%b",
                         $time, rsp.value, rsp.error);
                mismatches++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (rsp.value !== want.value)
                begin
                    $display("%0t: value mismatch: expected %h, got %h",
                             $time, want.value, rsp.value);
                    mismatches++;
                end
                if (rsp.error !== want.error)
                begin
                    $display("%0t: error flag mismatch: expected %b, got %b",
                             $time, want.error, rsp.error);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Raw draws straight out of reset: the sequence from seed 1
    task automatic test_reset_seed();
        repeat (3) send_request(make_req(CmdRaw, ValW'($urandom())));
        end_stream();
        wait_drained();
    endtask

    // Field extremes and the zero-range case
    task automatic test_draw_extremes();
        send_request(make_req(CmdRaw, '0));              // bound ignored on raw draws
        send_request(make_req(CmdRaw, FULL_SCALE));
        send_request(make_req(CmdRanged, '0));           // error, state holds
        send_request(make_req(CmdRaw, '0));              // must continue the same sequence
        send_request(make_req(CmdRanged, '0));
        send_request(make_req(CmdRanged, 31'd1));        // always zero
        send_request(make_req(CmdRanged, 31'd2));
        send_request(make_req(CmdRanged, 31'd3));
        send_request(make_req(CmdRanged, 31'd16));
        send_request(make_req(CmdRanged, 31'h3fffffff)); // divisor 2
        send_request(make_req(CmdRanged, 31'h40000000)); // divisor 1, half rejected
        send_request(make_req(CmdRanged, 31'h40000001));
        send_request(make_req(CmdRanged, 31'h7ffffffe));
        send_request(make_req(CmdRanged, FULL_SCALE));   // rejects only the top state
        end_stream();
        wait_drained();
    endtask

    // Seed loads: zero seed, bit 31 dropped, all ones
    task automatic test_seed_loads();
        write_seed(32'h0000_0000);
        send_request(make_req(CmdRaw, '0));
        send_request(make_req(CmdRanged, 31'd100));
        end_stream();
        wait_drained();
        write_seed(32'hffff_ffff);
        send_request(make_req(CmdRaw, '0));
        send_request(make_req(CmdRanged, FULL_SCALE));
        end_stream();
        wait_drained();
        write_seed(32'h8000_0000);                       // loads state 0
        send_request(make_req(CmdRaw, '0));
        end_stream();
        wait_drained();
        write_seed(32'h7fff_ffff);
        send_request(make_req(CmdRaw, '0));
        end_stream();
        wait_drained();
    endtask

    // Random items in phases, each with a fresh random seed; phase 1 runs without idling
    task automatic test_random_draws();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_seed($urandom());
            idling = (phase != 1);
            repeat (200) send_request(rand_request());
            end_stream();
            wait_drained();
        end
    endtask

    // Final stretch at full rate on both sides
    task automatic test_steady_tail();
        idling = 1'b0;
        write_seed($urandom());
        repeat (100) send_request(rand_request());
        end_stream();
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_seed();
        test_draw_extremes();
        test_seed_loads();
        test_random_draws();
        test_steady_tail();

        // let any stray result show up before the verdict
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lcgr_pkg.sv
hdl/lcgr_divider.sv
hdl/lcgr_datapath.sv
hdl/lcgr_ctrl.sv
hdl/lcg_random_with_range_top.sv
tb/testbench.sv
